[src/csra_pkg.sv]
// csra_pkg: shared types and constants of the contiguous sector run allocator.
// Used by csra_sdiv, the top level and the checker; depends on nothing.

package csra_pkg;

	localparam int REQ_W  = 3;
	localparam int IDX_W  = 13;
	localparam int SIZE_W = 23;
	localparam int MARK_W = 2;
	localparam int ST_W   = 2;
	localparam int LEN_W  = 14;
	localparam int TS_W   = 5;
	localparam int SKIP_W = 14;
	localparam int RSV_W  = 14;
	localparam int CFG_W  = 14;
	localparam int CFG_AW = 2;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - LEN_W;

	localparam int IN_START_LO = 0;
	localparam int IN_OLD_LO   = IN_START_LO + IDX_W;
	localparam int IN_NEW_LO   = IN_OLD_LO + SIZE_W;
	localparam int IN_MARK_LO  = IN_NEW_LO + SIZE_W;

	localparam logic [TS_W-1:0]   TABLE_SECTORS_RST  = TS_W'(16);
	localparam logic [SKIP_W-1:0] SKIP_ENTRIES_RST   = SKIP_W'(512);
	localparam logic [RSV_W-1:0]  RESERVE_PREFIX_RST = RSV_W'(14'h280);

	localparam logic [MARK_W-1:0] MARK_FREE = 2'd0;
	localparam logic [MARK_W-1:0] MARK_USED = 2'd1;
	localparam logic [MARK_W-1:0] MARK_END  = 2'd2;

	localparam logic [ST_W-1:0] STAT_DONE   = 2'd0;
	localparam logic [ST_W-1:0] STAT_NOROOM = 2'd1;
	localparam logic [ST_W-1:0] STAT_RANGE  = 2'd2;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC   = 3'd0,
		REQ_RELEASE = 3'd1,
		REQ_REALLOC = 3'd2,
		REQ_RESERVE = 3'd3,
		REQ_LOAD    = 3'd4
	} req_t;

	typedef enum logic [CFG_AW-1:0] {
		CFG_TABLE_SECTORS  = 2'd0,
		CFG_SKIP_ENTRIES   = 2'd1,
		CFG_RESERVE_PREFIX = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV_OLD,
		S_CHECK,
		S_FREE,
		S_DIV_NEW,
		S_SCAN,
		S_MARK,
		S_RSV,
		S_LOAD,
		S_FIN
	} state_t;

endpackage

[src/csra_ram.sv]
// csra_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.

module csra_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/csra_sdiv.sv]
// csra_sdiv: byte count to sector count, rounded up and at least one.
// Shift by the sector size (a power of two), result registered the cycle after start.
// Uses csra_pkg.

module csra_sdiv #(
	parameter int SECTOR_BYTES = 512,
	parameter int N_W          = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [csra_pkg::SIZE_W-1:0] bytes,
	output logic                       done,
	output logic [N_W-1:0]             sectors
);

	import csra_pkg::*;

	localparam int SH = $clog2(SECTOR_BYTES);
	localparam int QW = SIZE_W - SH;

	logic              done_q;
	logic [N_W-1:0]    sectors_q;
	logic [QW-1:0]     whole;
	logic              part;
	logic [N_W-1:0]    q_up;

	assign whole = bytes[SIZE_W-1:SH];
	assign part  = |bytes[SH-1:0];
	assign q_up  = N_W'(whole) + N_W'(part);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sectors_q <= (q_up == '0) ? N_W'(1) : q_up;
		end
	end

	assign sectors = sectors_q;
	assign done    = done_q;

endmodule

[src/contiguous_sector_run_allocator_unit.sv]
// contiguous_sector_run_allocator_unit: first-fit sector run allocator, top level.
// Uses csra_pkg, csra_ram (mark map) and csra_sdiv (size to sector count).
//
// channel  direction  handshake              payload
// s_axis   in         tvalid/tready          tuser: req_type; tdata: request fields
// m_axis   out        tvalid/tready          tuser: status;   tdata: run_start, run_length
// cfg      in         cfg_we (no wait)       cfg_addr: register, cfg_wdata: value
//
// After reset the map is swept clear with s_axis_tready low.
// One request at a time. Allocate: size conversion, then a scan from skip_entries
// (one map read per cycle), then the sectors of the run are marked. Release: size
// conversion, range check, then the sectors are freed; reallocate: a release, then an
// allocate. Reserve: free prefix entries set to MARK_END; load: one mark written.
// A new request is taken while the previous result waits on m_axis_tready.

module contiguous_sector_run_allocator_unit #(
	parameter int MAP_DEPTH    = 8192,
	parameter int SECTOR_BYTES = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// start_index[12:0], old_size_bytes[35:13], new_size_bytes[58:36], mark_value[60:59]
	input  logic [csra_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// req_type[2:0]
	input  logic [csra_pkg::REQ_W-1:0]        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// run_start[12:0], run_length[26:13]
	output logic [csra_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// status[1:0]
	output logic [csra_pkg::ST_W-1:0]         m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [csra_pkg::CFG_AW-1:0]       cfg_addr,
	input  logic [csra_pkg::CFG_W-1:0]        cfg_wdata
);

	import csra_pkg::*;

	localparam int AW  = $clog2(MAP_DEPTH);
	localparam int IW  = $clog2(MAP_DEPTH + 1);
	localparam int N_W = $clog2((2 ** SIZE_W) / SECTOR_BYTES + 2);
	localparam int PW  = TS_W + $clog2(SECTOR_BYTES + 1);
	localparam int LW  = (PW > IW) ? PW : IW;
	localparam int R1  = (N_W > IW) ? N_W : IW;
	localparam int R2  = (R1 > IDX_W) ? R1 : IDX_W;
	localparam int RW  = ((R2 > SKIP_W) ? R2 : SKIP_W) + 1;

	state_t state_q, state_d;

	logic [TS_W-1:0]   tsec_q;
	logic [SKIP_W-1:0] skip_q;
	logic [RSV_W-1:0]  rsv_q;

	logic [REQ_W-1:0]  req_q;
	logic [IDX_W-1:0]  start_q;
	logic [SIZE_W-1:0] new_q;
	logic [MARK_W-1:0] mark_q;
	logic [N_W-1:0]    n_old_q;
	logic [N_W-1:0]    n_new_q;
	logic [N_W-1:0]    cnt_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     first_q;
	logic [IW-1:0]     last_q;
	logic [IW-1:0]     pos_s1;
	logic              rd_vld_s1;

	logic [ST_W-1:0]   res_status_q;
	logic [IDX_W-1:0]  res_start_q;
	logic [LEN_W-1:0]  res_len_q;
	logic              out_vld_q;
	logic [ST_W-1:0]   out_status_q;
	logic [IDX_W-1:0]  out_start_q;
	logic [LEN_W-1:0]  out_len_q;

	logic [IDX_W-1:0]  in_start;
	logic [SIZE_W-1:0] in_old;
	logic [SIZE_W-1:0] in_new;
	logic [MARK_W-1:0] in_mark;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [MARK_W-1:0] mem_wdata, mem_rdata;

	logic              div_start, div_done;
	logic [SIZE_W-1:0] div_bytes;
	logic [N_W-1:0]    div_sectors;

	logic [LW-1:0]     lim_full;
	logic [IW-1:0]     lim;
	logic [IW-1:0]     rlim;
	logic              in_acc, in_known, clr_last, range_bad, free_last, skip_bad;
	logic              scan_issue, hit, scan_end, rsv_issue, rsv_end, load_ok, fin_go;

	assign in_start = s_axis_tdata[IN_START_LO +: IDX_W];
	assign in_old   = s_axis_tdata[IN_OLD_LO +: SIZE_W];
	assign in_new   = s_axis_tdata[IN_NEW_LO +: SIZE_W];
	assign in_mark  = s_axis_tdata[IN_MARK_LO +: MARK_W];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_known      = (s_axis_tuser == REQ_ALLOC) || (s_axis_tuser == REQ_RELEASE) ||
	                       (s_axis_tuser == REQ_REALLOC) || (s_axis_tuser == REQ_RESERVE) ||
	                       (s_axis_tuser == REQ_LOAD);

	assign lim_full = LW'(tsec_q) * LW'(SECTOR_BYTES);
	assign lim      = (lim_full > LW'(MAP_DEPTH)) ? IW'(MAP_DEPTH) : IW'(lim_full);
	assign rlim     = (RW'(rsv_q) > RW'(MAP_DEPTH)) ? IW'(MAP_DEPTH) : IW'(rsv_q);

	assign clr_last   = (idx_q == IW'(MAP_DEPTH - 1));
	assign range_bad  = (RW'(start_q) + RW'(n_old_q)) > RW'(lim);
	assign free_last  = (RW'(idx_q) + RW'(1)) == (RW'(start_q) + RW'(n_old_q));
	assign skip_bad   = RW'(skip_q) >= RW'(lim);
	assign scan_issue = idx_q < lim;
	assign hit        = rd_vld_s1 && (mem_rdata == MARK_FREE) &&
	                    ((cnt_q + N_W'(1)) == n_new_q);
	assign scan_end   = !scan_issue && !rd_vld_s1;
	assign rsv_issue  = idx_q < rlim;
	assign rsv_end    = !rsv_issue && !rd_vld_s1;
	assign load_ok    = (mark_q <= MARK_END) && (RW'(start_q) < RW'(MAP_DEPTH));
	assign fin_go     = !out_vld_q || m_axis_tready;

	csra_ram #(
		.WIDTH(MARK_W),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	csra_sdiv #(
		.SECTOR_BYTES(SECTOR_BYTES),
		.N_W         (N_W)
	) u_sdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.bytes  (div_bytes),
		.done   (div_done),
		.sectors(div_sectors)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) begin
					case (s_axis_tuser)
						REQ_ALLOC:   state_d = S_DIV_NEW;
						REQ_RELEASE: state_d = S_DIV_OLD;
						REQ_REALLOC: state_d = S_DIV_OLD;
						REQ_RESERVE: state_d = S_RSV;
						REQ_LOAD:    state_d = S_LOAD;
						default:     state_d = S_FIN;
					endcase
				end
			end
			S_DIV_OLD: begin
				if (div_done) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = range_bad ? S_FIN : S_FREE;
			end
			S_FREE: begin
				if (free_last) state_d = (req_q == REQ_REALLOC) ? S_DIV_NEW : S_FIN;
			end
			S_DIV_NEW: begin
				if (div_done) state_d = skip_bad ? S_FIN : S_SCAN;
			end
			S_SCAN: begin
				if (hit) state_d = S_MARK;
				else if (scan_end) state_d = S_FIN;
			end
			S_MARK: begin
				if (idx_q == last_q) state_d = S_FIN;
			end
			S_RSV: begin
				if (rsv_end) state_d = S_FIN;
			end
			S_LOAD: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (fin_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = MARK_FREE;
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		div_start = 1'b0;
		div_bytes = new_q;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				div_start = in_acc && ((s_axis_tuser == REQ_ALLOC) ||
				            (s_axis_tuser == REQ_RELEASE) || (s_axis_tuser == REQ_REALLOC));
				div_bytes = (s_axis_tuser == REQ_ALLOC) ? in_new : in_old;
			end
			S_FREE: begin
				mem_we    = 1'b1;
				div_start = free_last && (req_q == REQ_REALLOC);
			end
			S_SCAN: begin
				mem_re = scan_issue && !hit;
			end
			S_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = (idx_q == last_q) ? MARK_END : MARK_USED;
			end
			S_RSV: begin
				mem_re    = rsv_issue;
				mem_we    = rd_vld_s1 && (mem_rdata == MARK_FREE);
				mem_waddr = pos_s1[AW-1:0];
				mem_wdata = MARK_END;
			end
			S_LOAD: begin
				mem_we    = load_ok;
				mem_waddr = AW'(start_q);
				mem_wdata = mark_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsec_q <= TABLE_SECTORS_RST;
			skip_q <= SKIP_ENTRIES_RST;
			rsv_q  <= RESERVE_PREFIX_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_TABLE_SECTORS:  tsec_q <= cfg_wdata[TS_W-1:0];
				CFG_SKIP_ENTRIES:   skip_q <= cfg_wdata[SKIP_W-1:0];
				CFG_RESERVE_PREFIX: rsv_q  <= cfg_wdata[RSV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_re;
			if ((state_q == S_FIN) && fin_go) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: idx_q <= clr_last ? '0 : idx_q + IW'(1);
				S_IDLE:  idx_q <= '0;
				S_CHECK: idx_q <= IW'(start_q);
				S_FREE:  idx_q <= idx_q + IW'(1);
				S_DIV_NEW: begin
					if (div_done) idx_q <= IW'(skip_q);
				end
				S_SCAN: begin
					if (hit) idx_q <= IW'(pos_s1 + IW'(1) - IW'(n_new_q));
					else if (mem_re) idx_q <= idx_q + IW'(1);
				end
				S_MARK:  idx_q <= idx_q + IW'(1);
				S_RSV: begin
					if (mem_re) idx_q <= idx_q + IW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					req_q        <= s_axis_tuser;
					start_q      <= in_start;
					new_q        <= in_new;
					mark_q       <= in_mark;
					res_status_q <= in_known ? STAT_DONE : STAT_RANGE;
					res_start_q  <= '0;
					res_len_q    <= '0;
				end
			end
			S_DIV_OLD: begin
				if (div_done) n_old_q <= div_sectors;
			end
			S_CHECK: begin
				if (range_bad) res_status_q <= STAT_RANGE;
			end
			S_DIV_NEW: begin
				if (div_done) begin
					n_new_q <= div_sectors;
					cnt_q   <= '0;
					if (skip_bad) res_status_q <= STAT_NOROOM;
				end
			end
			S_SCAN: begin
				if (rd_vld_s1) begin
					cnt_q <= (mem_rdata == MARK_FREE) ? cnt_q + N_W'(1) : '0;
				end
				if (hit) begin
					first_q <= IW'(pos_s1 + IW'(1) - IW'(n_new_q));
					last_q  <= pos_s1;
				end else if (scan_end) begin
					res_status_q <= STAT_NOROOM;
				end
			end
			S_MARK: begin
				if (idx_q == last_q) begin
					res_start_q <= IDX_W'(first_q);
					res_len_q   <= LEN_W'(n_new_q);
				end
			end
			S_LOAD: begin
				if (!load_ok) res_status_q <= STAT_RANGE;
			end
			S_FIN: begin
				if (fin_go) begin
					out_status_q <= res_status_q;
					out_start_q  <= res_start_q;
					out_len_q    <= res_len_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_len_q, out_start_q};

endmodule

[src/csra_checker.sv]
// csra_checker: port-level assertions for the sector run allocator, bound to the top.
// Uses csra_pkg; sees only the top level ports.

module csra_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [csra_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic [csra_pkg::ST_W-1:0]         m_axis_tuser
);

	import csra_pkg::*;

	// one request in flight: ready drops right after an item is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while another is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(m_axis_tuser == STAT_DONE) || (m_axis_tuser == STAT_NOROOM) ||
		(m_axis_tuser == STAT_RANGE))
		else $error("undefined status code");

	// failed requests carry no run
	a_fail_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STAT_DONE) |-> (m_axis_tdata == '0))
		else $error("failed request reports a run");

endmodule

bind contiguous_sector_run_allocator_unit csra_checker u_csra_checker (.*);
